// ===== rtl/core/sfe_pkg.sv =====
// Shared types and constants for the stereo feedback echo.
// No dependencies; sfe_lane and stereo_feedback_echo refer to it by scoped names.
package sfe_pkg;

  localparam int DELAY_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);

  localparam int SAMPLE_W    = 32;
  localparam int GAIN_W      = 15;
  localparam int LEN_W       = 13;
  localparam int CFG_DATA_W  = 15;
  localparam int FRAC_W      = 15;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int ECHO_W      = PROD_W - FRAC_W;
  localparam int SUM_W       = ECHO_W + 1;
  localparam int RAM_W       = 2 * SAMPLE_W;

  localparam logic [GAIN_W-1:0] RESET_GAIN  = GAIN_W'(26214);
  localparam logic [LEN_W-1:0]  RESET_DELAY = LEN_W'(3200);

  typedef enum logic [0:0] {
    REG_ECHO_GAIN    = 1'b0,
    REG_DELAY_LENGTH = 1'b1
  } reg_index_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

endpackage

// ===== rtl/core/sfe_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read of an address written on the same edge returns the old data.
// No dependencies.
module sfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sfe_lane.sv =====
// One channel of the echo datapath: gain multiply (registered), then
// round toward zero, add the input sample and saturate. Uses sfe_pkg.
module sfe_lane (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [sfe_pkg::SAMPLE_W-1:0]  stored,
  input  logic        [sfe_pkg::GAIN_W-1:0]    gain,
  input  logic signed [sfe_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [sfe_pkg::SAMPLE_W-1:0]  result
);

  logic signed [sfe_pkg::PROD_W-1:0]   product;
  logic signed [sfe_pkg::SAMPLE_W-1:0] sample_hold;
  logic signed [sfe_pkg::PROD_W-1:0]   biased;
  logic signed [sfe_pkg::ECHO_W-1:0]   echo;
  logic signed [sfe_pkg::SUM_W-1:0]    sum;

  always_ff @(posedge clk) begin
    if (load) begin
      product     <= sfe_pkg::PROD_W'(stored) *
                     sfe_pkg::PROD_W'($signed({1'b0, gain}));
      sample_hold <= sample;
    end
  end

  always_comb begin
    // bias negative products so the arithmetic shift truncates toward zero
    biased = product + (product[sfe_pkg::PROD_W-1]
                        ? sfe_pkg::PROD_W'((1 << sfe_pkg::FRAC_W) - 1)
                        : sfe_pkg::PROD_W'(0));
    echo   = biased[sfe_pkg::PROD_W-1:sfe_pkg::FRAC_W];
    sum    = sfe_pkg::SUM_W'(sample_hold) + sfe_pkg::SUM_W'(echo);
    if (sum[sfe_pkg::SUM_W-1:sfe_pkg::SAMPLE_W-1] == '0 ||
        sum[sfe_pkg::SUM_W-1:sfe_pkg::SAMPLE_W-1] == '1) begin
      result = sum[sfe_pkg::SAMPLE_W-1:0];
    end else if (sum[sfe_pkg::SUM_W-1]) begin
      result = {1'b1, {(sfe_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(sfe_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/core/stereo_feedback_echo.sv =====
// Stereo feedback echo: delay-line control, read-modify-write pipeline.
// Depends on sfe_pkg, sfe_ram and sfe_lane.
//
// Usage: stereo sample pairs enter on in_valid/in_ready/in_data and the
// echoed pairs leave on out_valid/out_ready/out_data, one result per input
// transaction, in order. Gain and delay length are written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Both delay lines share one 64-bit wide RAM entry per position. An item
// reads its entry at acceptance, is multiplied on its way into the add stage
// and writes the saturated result back as it moves into the output register.
// Throughput is one item per clock for delay lengths of three or more while
// out_ready stays high. When an item's position is still owned by an item in
// the multiply or add stage the input holds off until that write is done: at
// a delay length of one each item waits for the one before it, and at a
// length of two every second item waits.
// Reset (synchronous) empties the pipeline, loads gain 26214 and length
// 3200, and zeroes the position and the fill count; entries at or above
// the fill count read as zero, so no clearing pass runs after reset.
// When out_ready is low the output register holds, the stages behind it
// keep filling, and in_ready drops once they are full.
module stereo_feedback_echo (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sfe_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sfe_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [sfe_pkg::GAIN_W-1:0] echo_gain;
  logic [sfe_pkg::LEN_W-1:0]  delay_length;
  sfe_pkg::addr_t             pos;
  sfe_pkg::addr_t             pos_next;
  sfe_pkg::fill_t             fill;
  sfe_pkg::fill_t             len_eff;
  sfe_pkg::fill_t             pos_inc;

  logic                       s1_valid;
  sfe_pkg::in_item_t          s1_item;
  sfe_pkg::addr_t             s1_pos;
  logic                       s1_fresh;
  logic                       s2_valid;
  sfe_pkg::addr_t             s2_pos;

  logic                       accept;
  logic                       hazard;
  logic                       s1_adv;
  logic                       s2_adv;

  logic [sfe_pkg::RAM_W-1:0]  rdata;
  logic signed [sfe_pkg::SAMPLE_W-1:0] left_stored;
  logic signed [sfe_pkg::SAMPLE_W-1:0] right_stored;
  logic signed [sfe_pkg::SAMPLE_W-1:0] left_result;
  logic signed [sfe_pkg::SAMPLE_W-1:0] right_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_gain    <= sfe_pkg::RESET_GAIN;
      delay_length <= sfe_pkg::RESET_DELAY;
    end else if (cfg_we) begin
      case (sfe_pkg::reg_index_t'(cfg_index))
        sfe_pkg::REG_ECHO_GAIN:    echo_gain    <= cfg_data[sfe_pkg::GAIN_W-1:0];
        sfe_pkg::REG_DELAY_LENGTH: delay_length <= cfg_data[sfe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  always_comb begin
    s2_adv   = s2_valid && (!out_valid || out_ready);
    s1_adv   = s1_valid && (!s2_valid || s2_adv);
    // hold off while an in-flight item still has to write this position
    hazard   = (s1_valid && s1_pos == pos) || (s2_valid && s2_pos == pos);
    in_ready = (!s1_valid || s1_adv) && !hazard;
    accept   = in_valid && in_ready;
  end

  // position advance and wrap at the clamped delay length
  always_comb begin
    if (delay_length == '0) begin
      len_eff = sfe_pkg::fill_t'(1);
    end else if (int'(delay_length) > sfe_pkg::DELAY_DEPTH) begin
      len_eff = sfe_pkg::fill_t'(sfe_pkg::DELAY_DEPTH);
    end else begin
      len_eff = sfe_pkg::fill_t'(delay_length);
    end
    pos_inc = sfe_pkg::fill_t'(pos) + sfe_pkg::fill_t'(1);
    if (pos_inc >= len_eff) begin
      pos_next = '0;
    end else begin
      pos_next = sfe_pkg::addr_t'(pos_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      fill     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos_next;
        // positions are visited upward from zero, so pos never passes fill
        if (sfe_pkg::fill_t'(pos) == fill) begin
          fill <= fill + sfe_pkg::fill_t'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= in_data;
      s1_pos   <= pos;
      s1_fresh <= sfe_pkg::fill_t'(pos) < fill;
    end
    if (s1_adv) begin
      s2_pos <= s1_pos;
    end
    if (s2_adv) begin
      out_data.left_out  <= left_result;
      out_data.right_out <= right_result;
    end
  end

  sfe_ram #(
    .WIDTH (sfe_pkg::RAM_W),
    .DEPTH (sfe_pkg::DELAY_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (s2_adv),
    .waddr (s2_pos),
    .wdata ({left_result, right_result}),
    .re    (accept),
    .raddr (pos),
    .rdata (rdata)
  );

  // entries never written since reset read as zero
  always_comb begin
    if (s1_fresh) begin
      left_stored  = rdata[sfe_pkg::RAM_W-1:sfe_pkg::SAMPLE_W];
      right_stored = rdata[sfe_pkg::SAMPLE_W-1:0];
    end else begin
      left_stored  = '0;
      right_stored = '0;
    end
  end

  sfe_lane u_left_lane (
    .clk    (clk),
    .load   (s1_adv),
    .stored (left_stored),
    .gain   (echo_gain),
    .sample (s1_item.left_sample),
    .result (left_result)
  );

  sfe_lane u_right_lane (
    .clk    (clk),
    .load   (s1_adv),
    .stored (right_stored),
    .gain   (echo_gain),
    .sample (s1_item.right_sample),
    .result (right_result)
  );

endmodule

// ===== test/tb_stereo_feedback_echo.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the stereo feedback echo: directed rows, then random phases.
// Depends on sfe_pkg and stereo_feedback_echo; predicts each result from its own delay lines.
module tb_stereo_feedback_echo;

  localparam logic signed [sfe_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [sfe_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam int RANDOM_ITEMS = 850;
  localparam int CALM_TAIL    = 100;
  localparam int STALL_LIMIT  = 3000;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    sfe_pkg::reg_index_t             idx;
    logic [sfe_pkg::CFG_DATA_W-1:0]  word;
    sfe_pkg::in_item_t               item;
    bit                              typed;
    sfe_pkg::out_item_t              want;
  } step_t;

  typedef struct {
    sfe_pkg::out_item_t model;
    bit                 typed;
    sfe_pkg::out_item_t typed_val;
  } due_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  sfe_pkg::in_item_t               in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  sfe_pkg::out_item_t              out_data;
  logic                            cfg_we = 1'b0;
  logic                            cfg_index = 1'b0;
  logic [sfe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // typed expectation riding along with the current transaction
  logic                            lit_flag = 1'b0;
  sfe_pkg::out_item_t              lit_word = '0;

  bit                     idle_on = 1'b1;
  int                     miss_count = 0;
  int                     quiet_cycles = 0;
  int                     stall_left = 0;

  // predictor state
  logic signed [sfe_pkg::SAMPLE_W-1:0] left_line  [sfe_pkg::DELAY_DEPTH];
  logic signed [sfe_pkg::SAMPLE_W-1:0] right_line [sfe_pkg::DELAY_DEPTH];
  logic [sfe_pkg::GAIN_W-1:0]          gain_q15;
  logic [sfe_pkg::LEN_W-1:0]           loop_len;
  int                                  tap;
  due_t                                echo_due [$];
  step_t                               plan [$];

  stereo_feedback_echo dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // input plus gain times the held value, product truncated toward zero, sum saturated
  function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] add_echo(
      input logic signed [sfe_pkg::SAMPLE_W-1:0] x,
      input logic signed [sfe_pkg::SAMPLE_W-1:0] held);
    longint p;
    longint e;
    longint s;
    p = longint'(held) * longint'(gain_q15);
    if (p < 0) e = -((-p) >> sfe_pkg::FRAC_W);
    else e = p >> sfe_pkg::FRAC_W;
    s = longint'(x) + e;
    if (s > longint'(SAMPLE_MAX)) s = longint'(SAMPLE_MAX);
    if (s < longint'(SAMPLE_MIN)) s = longint'(SAMPLE_MIN);
    return s[sfe_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] draw_sample();
    int v;
    case ($urandom_range(0, 7))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2, 3: v = int'($urandom_range(0, 2000)) - 1000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic note_miss(input string what,
                           input logic signed [sfe_pkg::SAMPLE_W-1:0] want,
                           input logic signed [sfe_pkg::SAMPLE_W-1:0] got);
    miss_count++;
    if (miss_count <= 10)
      $display("%0t: %s mismatch: expected %0d (%h), got %0d (%h)",
               $realtime, what, want, want, got, got);
  endtask

  task automatic compare_pair(input string tag, input sfe_pkg::out_item_t want,
                              input sfe_pkg::out_item_t got);
    if (got.left_out !== want.left_out) note_miss({tag, " left_out"}, want.left_out, got.left_out);
    if (got.right_out !== want.right_out)
      note_miss({tag, " right_out"}, want.right_out, got.right_out);
  endtask

  // Prediction and checking, all on the rising edge.
  always @(posedge clk) begin : scoreboard
    due_t               pending;
    sfe_pkg::out_item_t next;
    int                 len_eff;
    if (rst) begin
      gain_q15 = sfe_pkg::RESET_GAIN;
      loop_len = sfe_pkg::RESET_DELAY;
      tap = 0;
      for (int i = 0; i < sfe_pkg::DELAY_DEPTH; i++) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
    end else begin
      // pop before push so a stray result never matches the transaction of this edge
      if (out_valid && out_ready) begin
        if (echo_due.size() == 0) begin
          note_miss("unexpected result", '0, out_data.left_out);
        end else begin
          pending = echo_due.pop_front();
          compare_pair("predicted", pending.model, out_data);
          if (pending.typed) compare_pair("directed", pending.typed_val, out_data);
        end
      end
      if (cfg_we) begin
        if (cfg_index == sfe_pkg::REG_ECHO_GAIN) gain_q15 = cfg_data[sfe_pkg::GAIN_W-1:0];
        else loop_len = cfg_data[sfe_pkg::LEN_W-1:0];
      end
      if (in_valid && in_ready) begin
        len_eff = (loop_len == 0) ? 1 :
                  (loop_len > sfe_pkg::DELAY_DEPTH) ? sfe_pkg::DELAY_DEPTH : loop_len;
        next.left_out  = add_echo(in_data.left_sample, left_line[tap]);
        next.right_out = add_echo(in_data.right_sample, right_line[tap]);
        left_line[tap]  = next.left_out;
        right_line[tap] = next.right_out;
        tap = tap + 1;
        if (tap >= len_eff) tap = 0;
        pending.model     = next;
        pending.typed     = lit_flag;
        pending.typed_val = lit_word;
        echo_due.push_back(pending);
      end
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic push_sample(input sfe_pkg::in_item_t item, input bit typed,
                             input sfe_pkg::out_item_t want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    lit_flag <= typed;
    lit_word <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back, then let the pipeline settle.
  task automatic wait_quiet(input int tail);
    in_valid <= 1'b0;
    while (echo_due.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_reg(input sfe_pkg::reg_index_t idx,
                           input logic [sfe_pkg::CFG_DATA_W-1:0] word);
    wait_quiet(4);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_sample(input logic signed [sfe_pkg::SAMPLE_W-1:0] l,
                            input logic signed [sfe_pkg::SAMPLE_W-1:0] r);
    step_t s;
    s.kind = ROW_SAMPLE;
    s.idx = sfe_pkg::REG_ECHO_GAIN;
    s.word = '0;
    s.item = '{left_sample: l, right_sample: r};
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endtask

  task automatic add_checked(input logic signed [sfe_pkg::SAMPLE_W-1:0] l,
                             input logic signed [sfe_pkg::SAMPLE_W-1:0] r,
                             input logic signed [sfe_pkg::SAMPLE_W-1:0] wl,
                             input logic signed [sfe_pkg::SAMPLE_W-1:0] wr);
    step_t s;
    s.kind = ROW_SAMPLE;
    s.idx = sfe_pkg::REG_ECHO_GAIN;
    s.word = '0;
    s.item = '{left_sample: l, right_sample: r};
    s.typed = 1'b1;
    s.want = '{left_out: wl, right_out: wr};
    plan.push_back(s);
  endtask

  task automatic add_write(input sfe_pkg::reg_index_t idx,
                           input logic [sfe_pkg::CFG_DATA_W-1:0] word);
    step_t s;
    s.kind = ROW_WRITE;
    s.idx = idx;
    s.word = word;
    s.item = '0;
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endtask

  initial begin : stimulus
    step_t                           row;
    sfe_pkg::in_item_t               item;
    int                              issued;
    int                              phase;
    int                              span;
    int                              pause_at;
    int                              pick;
    int                              len;
    logic [sfe_pkg::CFG_DATA_W-1:0]  word;

    // reset values: empty lines, so the first transactions pass straight through
    add_checked(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    add_checked(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
    add_checked(0, -1, 0, -1);
    add_checked(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
    add_checked(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
    // shrink the loop below the current position: this one still uses the old slot
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'd1);
    add_checked(12345, -12345, 12345, -12345);
    // full gain against full-scale history saturates both ways
    add_write(sfe_pkg::REG_ECHO_GAIN, 15'd32767);
    add_checked(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    add_checked(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    add_sample(SAMPLE_MIN, SAMPLE_MAX);
    add_write(sfe_pkg::REG_ECHO_GAIN, 15'd0);
    add_checked(7, -7, 7, -7);
    // tiny gain on a negative value rounds toward zero, not down
    add_write(sfe_pkg::REG_ECHO_GAIN, 15'd1);
    add_checked(-1, 1, -1, 1);
    // zero length acts as one
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'd0);
    add_write(sfe_pkg::REG_ECHO_GAIN, 15'd16384);
    add_checked(100, -100, 100, -100);
    add_checked(0, 0, 50, -50);
    add_checked(0, 0, 25, -25);
    add_checked(0, 0, 12, -12);
    // oversized lengths clamp to the full depth
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'h7FFF);
    add_sample(-5, 5);
    add_sample(SAMPLE_MAX, SAMPLE_MIN);
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'd4097);
    add_sample(1, -1);
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'd2);
    add_sample(1000000, -1000000);
    add_sample(-3, 3);
    add_sample(SAMPLE_MIN, SAMPLE_MAX);
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'd4096);
    add_sample(42, -42);
    add_write(sfe_pkg::REG_ECHO_GAIN, 15'd26214);
    add_write(sfe_pkg::REG_DELAY_LENGTH, 15'd3);
    add_sample(SAMPLE_MAX, SAMPLE_MAX);
    add_sample(SAMPLE_MIN, SAMPLE_MIN);
    add_sample(-123456789, 987654321);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.word);
      else push_sample(row.item, row.typed, row.want);
    end

    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);

      pick = $urandom_range(0, 7);
      case (pick)
        0: word = '0;
        1: word = 15'd32767;
        2: word = sfe_pkg::RESET_GAIN;
        default: word = sfe_pkg::CFG_DATA_W'($urandom);
      endcase
      write_reg(sfe_pkg::REG_ECHO_GAIN, word);

      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(1, 12);
      else if (pick < 17) len = $urandom_range(13, 300);
      else if (pick == 17) len = 0;
      else if (pick == 18) len = $urandom_range(sfe_pkg::DELAY_DEPTH, 8191);
      else len = $urandom_range(1, sfe_pkg::DELAY_DEPTH);
      // upper data bits are dropped by the length register; toggle them anyway
      word = {2'($urandom_range(0, 3)), 13'(len)};
      write_reg(sfe_pkg::REG_DELAY_LENGTH, word);

      span = $urandom_range(20, 80);
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, span - 1) : -1;
      for (int k = 0; k < span && issued < RANDOM_ITEMS; k++) begin
        if (k == pause_at) wait_quiet(2);
        item.left_sample  = draw_sample();
        item.right_sample = draw_sample();
        push_sample(item, 1'b0, '0);
        issued++;
      end
      phase++;
    end

    wait_quiet(8);
    if (miss_count == 0 && echo_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== stereo_feedback_echo.f =====
rtl/core/sfe_pkg.sv
rtl/core/sfe_ram.sv
rtl/core/sfe_lane.sv
rtl/core/stereo_feedback_echo.sv
test/tb_stereo_feedback_echo.sv
